[hw/rtl/mmo_pkg.sv]
// ----------------------------------------------------------------------------
// mmo_pkg
// Shared types and constants of the macrocell maximum opacity block.
// ----------------------------------------------------------------------------
package mmo_pkg;

   localparam int VAL_W       = 32;
   localparam int OPAC_W      = 16;
   localparam int TAG_W       = 16;
   localparam int ENTRY_IDX_W = 8;
   localparam int ENTRIES_W   = 9;
   localparam int NM1_W       = ENTRIES_W;
   localparam int NUM_W       = VAL_W + NM1_W;
   localparam int DEN_W       = VAL_W;
   localparam int CSR_IDX_W   = 2;

   localparam int TABLE_DEPTH_DEFAULT = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_TF_LOW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TF_HIGH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TF_ENTRIES = 2'd2;

   localparam logic [VAL_W-1:0]     TF_LOW_RESET     = 32'd0;
   localparam logic [VAL_W-1:0]     TF_HIGH_RESET    = 32'd65535;
   localparam logic [ENTRIES_W-1:0] TF_ENTRIES_RESET = 9'd256;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                    op;
      logic [ENTRY_IDX_W-1:0]  entry_index;
      logic [OPAC_W-1:0]       entry_opacity;
      logic signed [VAL_W-1:0] range_low;
      logic signed [VAL_W-1:0] range_high;
      logic [TAG_W-1:0]        cell_tag;
   } req_type;

   typedef struct packed {
      logic [OPAC_W-1:0] max_opacity;
      logic [TAG_W-1:0]  result_tag;
      logic              range_error;
   } rsp_type;

endpackage

[hw/rtl/mmo_ram.sv]
// ----------------------------------------------------------------------------
// mmo_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mmo_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mmo_div.sv]
// ----------------------------------------------------------------------------
// mmo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmo_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mmo_pkg::NUM_W-1:0] dividend,
   input  logic [mmo_pkg::DEN_W-1:0] divisor,
   output logic                      done,
   output logic [mmo_pkg::NUM_W-1:0] quotient
);

   localparam int NW    = mmo_pkg::NUM_W;
   localparam int DW    = mmo_pkg::DEN_W;
   localparam int CNT_W = $clog2(NW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [DW:0]      shifted;
   logic [DW:0]      trial;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NW - 1);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && den_ff != '0) |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

[hw/rtl/macrocell_max_opacity.sv]
// ----------------------------------------------------------------------------
// macrocell_max_opacity
// Largest transfer-function opacity over a macrocell's value range.
//
// Channels: req_ carries a transaction that either writes one opacity table
// entry (op write) or queries a macrocell range (op query); rsp_ returns one
// result per query and none per write; csr_ writes tf_low, tf_high and
// tf_entries and is always ready.
// A write is taken in the idle state; writes can follow each other every cycle while no
// query is in progress. A query maps its two bounds to table indices one after the other,
// each through the one-bit-per-cycle divider, then scans one table entry per cycle from
// the lower to the upper index through the table RAM read port. An empty range or
// tf_high equal to tf_low skips the mappings and the scan.
// One item is worked on at a time; the next request is taken as soon as the
// current result sits in the output register, even if it is not yet taken.
// A stalled receiver holds the result; a following query waits at its end
// until the output register frees.
// Reset clears control state and sets the registers to tf_low 0,
// tf_high 65535, tf_entries 256; table entries are undefined until written.
// ----------------------------------------------------------------------------
module macrocell_max_opacity #(
   parameter int TABLE_DEPTH = mmo_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mmo_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mmo_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mmo_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mmo_pkg::VAL_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int VW    = mmo_pkg::VAL_W;
   localparam int NW    = mmo_pkg::NUM_W;
   localparam int MW    = mmo_pkg::NM1_W;
   localparam int OW    = mmo_pkg::OPAC_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PREP  = 4'd1;
   localparam logic [3:0] S_DIFF  = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_DIVGO = 4'd4;
   localparam logic [3:0] S_DIVW  = 4'd5;
   localparam logic [3:0] S_SETUP = 4'd6;
   localparam logic [3:0] S_SCAN  = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0]                       state_ff, state_in;
   logic [VW-1:0]                    tf_low_ff, tf_low_in;
   logic [VW-1:0]                    tf_high_ff, tf_high_in;
   logic [mmo_pkg::ENTRIES_W-1:0]    tf_entries_ff, tf_entries_in;
   logic signed [VW-1:0]             lo_v_ff, lo_v_in;
   logic signed [VW-1:0]             hi_v_ff, hi_v_in;
   logic [mmo_pkg::TAG_W-1:0]        tag_ff, tag_in;
   logic [VW-1:0]                    span_abs_ff, span_abs_in;
   logic                             span_neg_ff, span_neg_in;
   logic [MW-1:0]                    nm1_ff, nm1_in;
   logic                             sel_hi_ff, sel_hi_in;
   logic [VW-1:0]                    diff_abs_ff, diff_abs_in;
   logic                             diff_neg_ff, diff_neg_in;
   logic [NW-1:0]                    num_ff, num_in;
   logic                             neg_ff, neg_in;
   logic [IDX_W-1:0]                 lo_idx_ff, lo_idx_in;
   logic [IDX_W-1:0]                 hi_idx_ff, hi_idx_in;
   logic [IDX_W-1:0]                 addr_ff, addr_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic                             rd_last_ff, rd_last_in;
   logic [OW-1:0]                    best_ff, best_in;
   logic                             err_ff, err_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   mmo_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                             req_fire;
   logic                             tbl_wr_en;
   logic [OW-1:0]                    tbl_rd_data;
   logic                             div_start;
   logic                             div_done;
   logic [NW-1:0]                    div_quo;
   logic signed [VW:0]               span_w;
   logic signed [VW:0]               diff_w;
   logic signed [VW-1:0]             sel_v;
   logic [NW-1:0]                    nm1_w;
   logic [NW-1:0]                    idx_w;
   logic                             out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign tbl_wr_en = req_fire && (req_data.op == mmo_pkg::OP_WRITE) &&
                      (32'(req_data.entry_index) < TABLE_DEPTH);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   mmo_ram #(
      .WIDTH (OW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (IDX_W'(req_data.entry_index)),
      .wr_data (req_data.entry_opacity),
      .rd_addr (addr_ff),
      .rd_data (tbl_rd_data)
   );

   mmo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (span_abs_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      tf_low_in     = tf_low_ff;
      tf_high_in    = tf_high_ff;
      tf_entries_in = tf_entries_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mmo_pkg::CSR_TF_LOW:     tf_low_in     = csr_data;
            mmo_pkg::CSR_TF_HIGH:    tf_high_in    = csr_data;
            mmo_pkg::CSR_TF_ENTRIES: tf_entries_in = csr_data[mmo_pkg::ENTRIES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      span_w = $signed({tf_high_ff[VW-1], tf_high_ff}) - $signed({tf_low_ff[VW-1], tf_low_ff});
      sel_v  = sel_hi_ff ? hi_v_ff : lo_v_ff;
      diff_w = $signed({sel_v[VW-1], sel_v}) - $signed({tf_low_ff[VW-1], tf_low_ff});
      nm1_w  = NW'(nm1_ff);
      if (neg_ff && div_quo != '0) begin
         idx_w = '0;
      end else if (sel_hi_ff) begin
         idx_w = (div_quo >= nm1_w) ? nm1_w : div_quo + 1'b1;
      end else begin
         idx_w = (div_quo > nm1_w) ? nm1_w : div_quo;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lo_v_in      = lo_v_ff;
      hi_v_in      = hi_v_ff;
      tag_in       = tag_ff;
      span_abs_in  = span_abs_ff;
      span_neg_in  = span_neg_ff;
      nm1_in       = nm1_ff;
      sel_hi_in    = sel_hi_ff;
      diff_abs_in  = diff_abs_ff;
      diff_neg_in  = diff_neg_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      lo_idx_in    = lo_idx_ff;
      hi_idx_in    = hi_idx_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      best_in      = best_ff;
      err_in       = err_ff;
      div_start    = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (rd_vld_ff && tbl_rd_data > best_ff) begin
         best_in = tbl_rd_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_data.op == mmo_pkg::OP_QUERY) begin
               lo_v_in  = req_data.range_low;
               hi_v_in  = req_data.range_high;
               tag_in   = req_data.cell_tag;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            best_in     = '0;
            err_in      = 1'b0;
            sel_hi_in   = 1'b0;
            span_neg_in = span_w[VW];
            span_abs_in = span_w[VW] ? VW'(-span_w) : VW'(span_w);
            if (tf_entries_ff == '0) begin
               nm1_in = '0;
            end else if (32'(tf_entries_ff) > TABLE_DEPTH) begin
               nm1_in = MW'(TABLE_DEPTH - 1);
            end else begin
               nm1_in = tf_entries_ff - 1'b1;
            end
            if (hi_v_ff < lo_v_ff) begin
               state_in = S_DONE;
            end else if (span_w == '0) begin
               err_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_neg_in = diff_w[VW];
            diff_abs_in = diff_w[VW] ? VW'(-diff_w) : VW'(diff_w);
            state_in    = S_MUL;
         end
         S_MUL: begin
            num_in   = NW'(diff_abs_ff) * NW'(nm1_ff);
            neg_in   = diff_neg_ff ^ span_neg_ff;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               if (sel_hi_ff) begin
                  hi_idx_in = IDX_W'(idx_w);
                  state_in  = S_SETUP;
               end else begin
                  lo_idx_in = IDX_W'(idx_w);
                  sel_hi_in = 1'b1;
                  state_in  = S_DIFF;
               end
            end
         end
         S_SETUP: begin
            addr_in  = lo_idx_ff;
            state_in = (lo_idx_ff > hi_idx_ff) ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            rd_vld_in  = 1'b1;
            rd_last_in = (addr_ff == hi_idx_ff);
            addr_in    = addr_ff + 1'b1;
            if (addr_ff == hi_idx_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.max_opacity = best_ff;
               rsp_data_in.result_tag  = tag_ff;
               rsp_data_in.range_error = err_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tf_low_ff     <= mmo_pkg::TF_LOW_RESET;
         tf_high_ff    <= mmo_pkg::TF_HIGH_RESET;
         tf_entries_ff <= mmo_pkg::TF_ENTRIES_RESET;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tf_low_ff     <= tf_low_in;
         tf_high_ff    <= tf_high_in;
         tf_entries_ff <= tf_entries_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lo_v_ff     <= lo_v_in;
      hi_v_ff     <= hi_v_in;
      tag_ff      <= tag_in;
      span_abs_ff <= span_abs_in;
      span_neg_ff <= span_neg_in;
      nm1_ff      <= nm1_in;
      sel_hi_ff   <= sel_hi_in;
      diff_abs_ff <= diff_abs_in;
      diff_neg_ff <= diff_neg_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      lo_idx_ff   <= lo_idx_in;
      hi_idx_ff   <= hi_idx_in;
      addr_ff     <= addr_in;
      best_ff     <= best_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_scan_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (addr_ff <= hi_idx_ff))
      else $error("scan address past upper index");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (32'(hi_idx_ff) <= 32'(nm1_ff)))
      else $error("upper index beyond entries in use");

   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (rd_vld_ff && rd_last_ff))
      else $error("drain without last table read in flight");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> !rd_vld_ff)
      else $error("table read still in flight at result");

endmodule

[tb/macrocell_max_opacity_test.sv]
// ----------------------------------------------------------------------------
// macrocell_max_opacity_test
// Drives opacity table writes and macrocell range queries into the block,
// changes tf_low, tf_high and tf_entries between phases while the block is
// idle, and checks every result against a typed expected result or an in-bench
// maximum opacity predictor. A short table of directed transactions is followed by random
// phases. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module macrocell_max_opacity_test;

   localparam int TABLE_DEPTH     = mmo_pkg::TABLE_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES   = 400;
   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_ITEMS     = 72;
   localparam int CYCLE_LIMIT     = 2000000;

   localparam logic [mmo_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [mmo_pkg::VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam longint VAL_FLOOR = -64'sd2147483648;
   localparam longint VAL_CEIL  = 64'sd2147483647;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [mmo_pkg::CSR_IDX_W-1:0] csr_index;
      logic [mmo_pkg::VAL_W-1:0]     csr_value;
      mmo_pkg::req_type              item;
      logic                          typed;
      mmo_pkg::rsp_type              want;
   } plan_row_type;

   logic                            clock;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   mmo_pkg::req_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   mmo_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [mmo_pkg::CSR_IDX_W-1:0]   csr_index = mmo_pkg::CSR_TF_LOW;
   logic [mmo_pkg::VAL_W-1:0]       csr_data  = '0;

   logic [mmo_pkg::OPAC_W-1:0]      opacity_shadow [TABLE_DEPTH];
   logic [mmo_pkg::VAL_W-1:0]       tf_low_q     = mmo_pkg::TF_LOW_RESET;
   logic [mmo_pkg::VAL_W-1:0]       tf_high_q    = mmo_pkg::TF_HIGH_RESET;
   logic [mmo_pkg::ENTRIES_W-1:0]   tf_entries_q = mmo_pkg::TF_ENTRIES_RESET;

   mmo_pkg::rsp_type                pending_results [$];
   plan_row_type                    directed_plan [$];
   int                              mismatch_count = 0;
   int                              cycle_count    = 0;
   bit                              req_idle_on    = 1'b1;
   bit                              rsp_idle_on    = 1'b1;

   macrocell_max_opacity #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic mmo_pkg::req_type mk_write(
      input logic [mmo_pkg::ENTRY_IDX_W-1:0] idx,
      input logic [mmo_pkg::OPAC_W-1:0]      opacity);
      mmo_pkg::req_type it;
      it.op            = mmo_pkg::OP_WRITE;
      it.entry_index   = idx;
      it.entry_opacity = opacity;
      it.range_low     = $urandom;
      it.range_high    = $urandom;
      it.cell_tag      = 16'($urandom);
      return it;
   endfunction

   function automatic mmo_pkg::req_type mk_query(
      input logic [mmo_pkg::VAL_W-1:0] lo,
      input logic [mmo_pkg::VAL_W-1:0] hi,
      input logic [mmo_pkg::TAG_W-1:0] tag);
      mmo_pkg::req_type it;
      it.op            = mmo_pkg::OP_QUERY;
      it.entry_index   = 8'($urandom);
      it.entry_opacity = 16'($urandom);
      it.range_low     = lo;
      it.range_high    = hi;
      it.cell_tag      = tag;
      return it;
   endfunction

   function automatic mmo_pkg::rsp_type mk_result(
      input logic [mmo_pkg::OPAC_W-1:0] opacity,
      input logic [mmo_pkg::TAG_W-1:0]  tag,
      input logic                       err);
      mmo_pkg::rsp_type r;
      r.max_opacity = opacity;
      r.result_tag  = tag;
      r.range_error = err;
      return r;
   endfunction

   function automatic void add_req(input mmo_pkg::req_type it, input logic typed,
                                   input mmo_pkg::rsp_type want);
      plan_row_type row;
      row           = '0;
      row.kind      = ROW_REQ;
      row.item      = it;
      row.typed     = typed;
      row.want      = want;
      directed_plan.push_back(row);
   endfunction

   function automatic void add_csr(input logic [mmo_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [mmo_pkg::VAL_W-1:0] value);
      plan_row_type row;
      row           = '0;
      row.kind      = ROW_CSR;
      row.csr_index = idx;
      row.csr_value = value;
      directed_plan.push_back(row);
   endfunction

   function automatic longint clamp_index(input longint i, input longint top);
      if (i < 0)
         return 0;
      if (i > top)
         return top;
      return i;
   endfunction

   function automatic mmo_pkg::rsp_type predict_max_opacity(input mmo_pkg::req_type q);
      mmo_pkg::rsp_type r;
      longint           base, span, n, lo_v, hi_v, lo_i, hi_i, idx;
      r             = '0;
      r.result_tag  = q.cell_tag;
      lo_v          = $signed(q.range_low);
      hi_v          = $signed(q.range_high);
      base          = $signed(tf_low_q);
      span          = $signed(tf_high_q);
      span          = span - base;
      n             = tf_entries_q;
      if (n < 1)
         n = 1;
      if (n > TABLE_DEPTH)
         n = TABLE_DEPTH;
      if (hi_v >= lo_v) begin
         if (span == 0) begin
            r.range_error = 1'b1;
         end else begin
            lo_i = clamp_index(((lo_v - base) * (n - 1)) / span, n - 1);
            hi_i = clamp_index(((hi_v - base) * (n - 1)) / span + 1, n - 1);
            for (idx = lo_i; idx <= hi_i; idx++) begin
               if (opacity_shadow[idx] > r.max_opacity)
                  r.max_opacity = opacity_shadow[idx];
            end
         end
      end
      return r;
   endfunction

   function automatic logic [mmo_pkg::VAL_W-1:0] near_value();
      longint          a, b, m, v;
      longint unsigned r;
      a = $signed(tf_low_q);
      b = $signed(tf_high_q);
      if (a > b) begin
         v = a;
         a = b;
         b = v;
      end
      m = (b - a) / 8 + 2;
      a = a - m;
      b = b + m;
      r = {$urandom, $urandom};
      v = a + longint'(r % longint'(b - a + 1));
      if (v < VAL_FLOOR)
         v = VAL_FLOOR;
      if (v > VAL_CEIL)
         v = VAL_CEIL;
      return v[mmo_pkg::VAL_W-1:0];
   endfunction

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [mmo_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mmo_pkg::VAL_W-1:0] value);
      quiesce();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         mmo_pkg::CSR_TF_LOW:     tf_low_q     = value;
         mmo_pkg::CSR_TF_HIGH:    tf_high_q    = value;
         mmo_pkg::CSR_TF_ENTRIES: tf_entries_q = value[mmo_pkg::ENTRIES_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_item(input mmo_pkg::req_type it, input logic typed,
                            input mmo_pkg::rsp_type want);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (it.op == mmo_pkg::OP_WRITE)
         opacity_shadow[it.entry_index] = it.entry_opacity;
      else if (typed)
         pending_results.push_back(want);
      else
         pending_results.push_back(predict_max_opacity(it));
   endtask

   // result side: random stalls, field-by-field compare
   initial begin
      mmo_pkg::rsp_type want;
      int               stall;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.max_opacity !== want.max_opacity) begin
               $display("%0t: max_opacity: expected %h, actual %h",
                        $time, want.max_opacity, rsp_data.max_opacity);
               mismatch_count++;
            end
            if (rsp_data.result_tag !== want.result_tag) begin
               $display("%0t: result_tag: expected %h, actual %h",
                        $time, want.result_tag, rsp_data.result_tag);
               mismatch_count++;
            end
            if (rsp_data.range_error !== want.range_error) begin
               $display("%0t: range_error: expected %b, actual %b",
                        $time, want.range_error, rsp_data.range_error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      plan_row_type                row;
      mmo_pkg::req_type            item;
      logic [mmo_pkg::VAL_W-1:0]   a, b, lo_cfg, hi_cfg, ent_cfg;
      int unsigned                 roll, ent;
      int                          i, phase, k;

      add_req(mk_query(32'd0, 32'd65535, 16'h0000), 1'b1,
              mk_result(16'h0000, 16'h0000, 1'b0));
      add_req(mk_write(8'd0, 16'hFFFF), 1'b0, '0);
      add_req(mk_write(8'd255, 16'h8000), 1'b0, '0);
      add_req(mk_write(8'd128, 16'h0001), 1'b0, '0);
      add_req(mk_query(32'd100, 32'd99, 16'hFFFF), 1'b1,
              mk_result(16'h0000, 16'hFFFF, 1'b0));
      add_req(mk_query(VAL_MIN, VAL_MAX, 16'h5A5A), 1'b1,
              mk_result(16'hFFFF, 16'h5A5A, 1'b0));
      add_req(mk_query(32'd65535, 32'd65535, 16'h0001), 1'b1,
              mk_result(16'h8000, 16'h0001, 1'b0));
      add_req(mk_query(-32'sd5, -32'sd1, 16'h0002), 1'b0, '0);
      add_req(mk_query(32'd32768, 32'd32896, 16'h0003), 1'b0, '0);
      add_csr(mmo_pkg::CSR_TF_ENTRIES, 32'd0);
      add_req(mk_query(32'd0, 32'd65535, 16'h0004), 1'b0, '0);
      add_csr(mmo_pkg::CSR_TF_ENTRIES, 32'h0000_01FF);
      add_req(mk_query(32'd65535, 32'd65535, 16'h0005), 1'b0, '0);
      add_csr(mmo_pkg::CSR_TF_HIGH, 32'd0);
      add_req(mk_query(32'd0, 32'd0, 16'h0006), 1'b1,
              mk_result(16'h0000, 16'h0006, 1'b1));
      add_req(mk_query(32'd1, 32'd0, 16'h0007), 1'b1,
              mk_result(16'h0000, 16'h0007, 1'b0));
      add_csr(mmo_pkg::CSR_TF_LOW, 32'd65535);
      add_csr(mmo_pkg::CSR_TF_ENTRIES, 32'd256);
      add_req(mk_query(32'd0, 32'd65535, 16'h0008), 1'b1,
              mk_result(16'h0000, 16'h0008, 1'b0));
      add_req(mk_query(32'd65535, 32'd65535, 16'h0009), 1'b0, '0);
      add_csr(mmo_pkg::CSR_TF_LOW, VAL_MIN);
      add_csr(mmo_pkg::CSR_TF_HIGH, VAL_MAX);
      add_req(mk_query(VAL_MIN, VAL_MIN, 16'h000A), 1'b0, '0);
      add_req(mk_query(VAL_MAX, VAL_MAX, 16'h000B), 1'b0, '0);
      add_req(mk_write(8'd255, 16'h0000), 1'b0, '0);
      add_req(mk_write(8'd0, 16'h7FFF), 1'b0, '0);
      add_req(mk_query(VAL_MIN, VAL_MAX, 16'h000C), 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // clear the whole table so no query reads an unwritten entry
      for (i = 0; i < TABLE_DEPTH; i++)
         send_item(mk_write(8'(i), 16'h0000), 1'b0, '0);

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_CSR)
            write_csr(row.csr_index, row.csr_value);
         else
            send_item(row.item, row.typed, row.want);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0: begin
               lo_cfg = VAL_MIN;
               hi_cfg = VAL_MAX;
            end
            1: begin
               lo_cfg = $urandom;
               hi_cfg = lo_cfg;
            end
            2: begin
               lo_cfg = $urandom;
               hi_cfg = $urandom;
            end
            default: begin
               lo_cfg = $urandom_range(0, 4000);
               lo_cfg = lo_cfg - 32'd2000;
               hi_cfg = lo_cfg + $urandom_range(1, 1 << 20);
            end
         endcase
         case ($urandom_range(0, 5))
            0:       ent = 0;
            1:       ent = 1;
            2:       ent = TABLE_DEPTH;
            3:       ent = $urandom_range(TABLE_DEPTH + 1, 511);
            default: ent = $urandom_range(2, TABLE_DEPTH);
         endcase
         ent_cfg = ($urandom & 32'hFFFF_FE00) | ent;
         write_csr(mmo_pkg::CSR_TF_LOW, lo_cfg);
         write_csr(mmo_pkg::CSR_TF_HIGH, hi_cfg);
         write_csr(mmo_pkg::CSR_TF_ENTRIES, ent_cfg);

         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 25 == 0) begin
               req_idle_on = ($urandom_range(0, 3) != 0);
               rsp_idle_on = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
               item = mk_write(8'($urandom), 16'($urandom));
            end else if (roll < 35) begin
               item = mk_query($urandom, $urandom, 16'($urandom));
            end else begin
               a = near_value();
               b = near_value();
               if (roll >= 90)
                  b = a;
               if (($signed(a) > $signed(b)) != (roll < 42))
                  item = mk_query(b, a, 16'($urandom));
               else
                  item = mk_query(a, b, 16'($urandom));
            end
            send_item(item, 1'b0, '0);
         end
      end

      quiesce();
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/mmo_pkg.sv
hw/rtl/mmo_ram.sv
hw/rtl/mmo_div.sv
hw/rtl/macrocell_max_opacity.sv
tb/macrocell_max_opacity_test.sv
